>>> rtl/itpc_pkg.sv
`timescale 1ns / 1ps

package itpc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int TIME_BITS_DEFAULT   = 32;

   localparam int LEVEL_BITS = 12;
   localparam int DELAY_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [LEVEL_BITS-1:0] OFF_LEVEL_RESET     = 12'd2100;
   localparam logic [LEVEL_BITS-1:0] ON_LEVEL_RESET      = 12'd2311;
   localparam logic [LEVEL_BITS-1:0] TRIGGER_LEVEL_RESET = 12'd1600;
   localparam logic [DELAY_BITS-1:0] SENSE_TIME_RESET    = 16'd1000;
   localparam logic [DELAY_BITS-1:0] PULSE_TIME_RESET    = 16'd500;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OFF_LEVEL     = 3'd0,
      CSR_ON_LEVEL      = 3'd1,
      CSR_TRIGGER_LEVEL = 3'd2,
      CSR_SENSE_TIME    = 3'd3,
      CSR_PULSE_TIME    = 3'd4
   } csr_index_type;

endpackage

>>> rtl/itpc_req_if.sv
`timescale 1ns / 1ps

interface itpc_req_if #(
   parameter int SAMPLE_BITS = itpc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = itpc_pkg::TIME_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] battery_sample;
   logic [SAMPLE_BITS-1:0] state_sample;
   logic [TIME_BITS-1:0]   now_ms;

   modport source (output valid, output battery_sample, output state_sample,
                   output now_ms, input ready);
   modport sink (input valid, input battery_sample, input state_sample,
                 input now_ms, output ready);
endinterface

>>> rtl/itpc_rsp_if.sv
`timescale 1ns / 1ps

interface itpc_rsp_if;
   logic valid;
   logic ready;
   logic switch_drive;
   logic sensing_flag;
   logic switching_flag;

   modport source (output valid, output switch_drive, output sensing_flag,
                   output switching_flag, input ready);
   modport sink (input valid, input switch_drive, input sensing_flag,
                 input switching_flag, output ready);
endinterface

>>> rtl/itpc_csr_if.sv
`timescale 1ns / 1ps

interface itpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [itpc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [itpc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/inverter_toggle_pulse_controller.sv
`timescale 1ns / 1ps

// An accepted item is held in the input register and its result is written to the output
// register. One item per cycle while results are taken (rsp_ch.ready); an input register
// and an output register split the two handshakes, and the state update is a single pass
// of compares and two subtractors.
// Reset (synchronous, active high) empties both registers, clears sensing and pulse
// state and loads the default thresholds and delays.
module inverter_toggle_pulse_controller #(
   parameter int SAMPLE_BITS = itpc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = itpc_pkg::TIME_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   itpc_req_if.sink  req_ch,
   itpc_rsp_if.source rsp_ch,
   itpc_csr_if.sink  csr_ch
);

   localparam int CMP_BITS = (TIME_BITS > itpc_pkg::DELAY_BITS) ?
                             TIME_BITS : itpc_pkg::DELAY_BITS;

   // Configuration registers
   logic [itpc_pkg::LEVEL_BITS-1:0] off_level_ff, on_level_ff, trigger_level_ff;
   logic [itpc_pkg::DELAY_BITS-1:0] sense_time_ff, pulse_time_ff;

   // Input register
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] bat_ff, st_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // Controller state
   logic                 sensing_ff, sensing_in;
   logic                 switching_ff, switching_in;
   logic [TIME_BITS-1:0] sense_start_ff, sense_start_in;
   logic [TIME_BITS-1:0] pulse_start_ff, pulse_start_in;

   // Output register
   logic rsp_valid_ff;
   logic switching_out_ff, sensing_out_ff;

   logic                   stage_fire, in_fire, out_free;
   logic [SAMPLE_BITS-1:0] offl, onl, trig;
   logic                   low_cond, high_cond;
   logic                   start_sense, sensing_mid, confirm, turn_on, pulse_new, switching_mid;
   logic [TIME_BITS-1:0]   sense_elapsed, pulse_elapsed;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign stage_fire    = in_valid_ff && out_free;
   assign req_ch.ready  = !in_valid_ff || out_free;
   assign in_fire       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_level_ff     <= itpc_pkg::OFF_LEVEL_RESET;
         on_level_ff      <= itpc_pkg::ON_LEVEL_RESET;
         trigger_level_ff <= itpc_pkg::TRIGGER_LEVEL_RESET;
         sense_time_ff    <= itpc_pkg::SENSE_TIME_RESET;
         pulse_time_ff    <= itpc_pkg::PULSE_TIME_RESET;
      end else if (csr_ch.valid) begin
         case (itpc_pkg::csr_index_type'(csr_ch.index))
            itpc_pkg::CSR_OFF_LEVEL: begin
               off_level_ff <= csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
            end
            itpc_pkg::CSR_ON_LEVEL: begin
               on_level_ff <= csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
            end
            itpc_pkg::CSR_TRIGGER_LEVEL: begin
               trigger_level_ff <= csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
            end
            itpc_pkg::CSR_SENSE_TIME: begin
               sense_time_ff <= csr_ch.data[itpc_pkg::DELAY_BITS-1:0];
            end
            itpc_pkg::CSR_PULSE_TIME: begin
               pulse_time_ff <= csr_ch.data[itpc_pkg::DELAY_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         bat_ff <= req_ch.battery_sample;
         st_ff  <= req_ch.state_sample;
         now_ff <= req_ch.now_ms;
      end
   end

   always_comb begin
      offl = SAMPLE_BITS'(off_level_ff);
      onl  = SAMPLE_BITS'(on_level_ff);
      trig = SAMPLE_BITS'(trigger_level_ff);

      low_cond  = (bat_ff <= offl) && (st_ff <= trig);
      high_cond = (bat_ff >= onl) && (st_ff >= trig);

      start_sense = !switching_ff && !sensing_ff && low_cond;
      // A start in this item means zero elapsed time.
      sense_elapsed = start_sense ? '0 : (now_ff - sense_start_ff);
      confirm = (sensing_ff || start_sense) &&
                (CMP_BITS'(sense_elapsed) >= CMP_BITS'(sense_time_ff));
      sensing_mid = (sensing_ff || start_sense) && !confirm;

      turn_on   = !(switching_ff || (confirm && low_cond)) && high_cond;
      pulse_new = (confirm && low_cond) || turn_on;
      switching_mid = switching_ff || pulse_new;

      pulse_elapsed = pulse_new ? '0 : (now_ff - pulse_start_ff);

      sensing_in     = sensing_mid;
      switching_in   = switching_mid &&
                       !(CMP_BITS'(pulse_elapsed) >= CMP_BITS'(pulse_time_ff));
      sense_start_in = start_sense ? now_ff : sense_start_ff;
      pulse_start_in = pulse_new ? now_ff : pulse_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensing_ff     <= 1'b0;
         switching_ff   <= 1'b0;
         sense_start_ff <= '0;
         pulse_start_ff <= '0;
      end else if (stage_fire) begin
         sensing_ff     <= sensing_in;
         switching_ff   <= switching_in;
         sense_start_ff <= sense_start_in;
         pulse_start_ff <= pulse_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         switching_out_ff <= switching_in;
         sensing_out_ff   <= sensing_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.switch_drive   = switching_out_ff;
   assign rsp_ch.switching_flag = switching_out_ff;
   assign rsp_ch.sensing_flag   = sensing_out_ff;

   // Sensing only ever starts from the idle condition.
   a_sense_from_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(sensing_ff) |-> !$past(switching_ff))
      else $error("sensing started while a pulse was running");

   // Controller state moves only when an item passes through the stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !stage_fire |=> ($stable(sensing_ff) && $stable(switching_ff) &&
                       $stable(sense_start_ff) && $stable(pulse_start_ff)))
      else $error("controller state changed without an item");

   // Every processed item lands in the output register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> rsp_valid_ff)
      else $error("processed item produced no result");

   // The result reflects the state written with it.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> (switching_out_ff == switching_ff && sensing_out_ff == sensing_ff))
      else $error("result does not match the updated state");

   // A held result blocks the stage, so the input register must not be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input register accepted an item while full and stalled");

endmodule

>>> verif/itpc_toggle_monitor.sv
`timescale 1ns / 1ps

module itpc_toggle_monitor (
   input  logic clock,
   input  logic reset,
   itpc_req_if  req_ch,
   itpc_rsp_if  rsp_ch,
   itpc_csr_if  csr_ch,
   output int   error_count,
   output int   outstanding
);

   typedef struct packed {
      logic switch_drive;
      logic sensing_flag;
      logic switching_flag;
   } toggle_outputs_type;

   logic [itpc_pkg::LEVEL_BITS-1:0]        off_level;
   logic [itpc_pkg::LEVEL_BITS-1:0]        on_level;
   logic [itpc_pkg::LEVEL_BITS-1:0]        trigger_level;
   logic [itpc_pkg::DELAY_BITS-1:0]        sense_time;
   logic [itpc_pkg::DELAY_BITS-1:0]        pulse_time;
   logic                                   sensing;
   logic                                   switching;
   logic [itpc_pkg::TIME_BITS_DEFAULT-1:0] sense_start;
   logic [itpc_pkg::TIME_BITS_DEFAULT-1:0] pulse_start;
   toggle_outputs_type                     expected_outputs[$];

   // Advances the controller state by one sample and returns the pin and flag levels.
   function automatic toggle_outputs_type predict_toggle(
      input logic [itpc_pkg::SAMPLE_BITS_DEFAULT-1:0] battery,
      input logic [itpc_pkg::SAMPLE_BITS_DEFAULT-1:0] sense_line,
      input logic [itpc_pkg::TIME_BITS_DEFAULT-1:0]   stamp
   );
      logic               low_battery_on;
      toggle_outputs_type outputs;
      low_battery_on = (battery <= off_level) && (sense_line <= trigger_level);
      if (!switching && !sensing && low_battery_on) begin
         sense_start = stamp;
         sensing     = 1'b1;
      end
      // The subtraction is 32 bits wide, so elapsed time wraps with the timestamp.
      if (sensing && (stamp - sense_start) >= sense_time) begin
         sensing = 1'b0;
         if (low_battery_on) begin
            pulse_start = stamp;
            switching   = 1'b1;
         end
      end
      if (!switching && battery >= on_level && sense_line >= trigger_level) begin
         pulse_start = stamp;
         switching   = 1'b1;
      end
      if (switching && (stamp - pulse_start) >= pulse_time) begin
         switching = 1'b0;
      end
      outputs.switch_drive   = switching;
      outputs.sensing_flag   = sensing;
      outputs.switching_flag = switching;
      return outputs;
   endfunction

   task automatic report_error(input string message);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] %s", $realtime, message);
      end
   endtask

   always @(posedge clock) begin
      toggle_outputs_type observed;
      toggle_outputs_type wanted;
      if (reset) begin
         off_level     = itpc_pkg::OFF_LEVEL_RESET;
         on_level      = itpc_pkg::ON_LEVEL_RESET;
         trigger_level = itpc_pkg::TRIGGER_LEVEL_RESET;
         sense_time    = itpc_pkg::SENSE_TIME_RESET;
         pulse_time    = itpc_pkg::PULSE_TIME_RESET;
         sensing       = 1'b0;
         switching     = 1'b0;
         sense_start   = '0;
         pulse_start   = '0;
         expected_outputs.delete();
         outstanding   = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               itpc_pkg::CSR_OFF_LEVEL: begin
                  off_level = csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
               end
               itpc_pkg::CSR_ON_LEVEL: begin
                  on_level = csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
               end
               itpc_pkg::CSR_TRIGGER_LEVEL: begin
                  trigger_level = csr_ch.data[itpc_pkg::LEVEL_BITS-1:0];
               end
               itpc_pkg::CSR_SENSE_TIME: begin
                  sense_time = csr_ch.data[itpc_pkg::DELAY_BITS-1:0];
               end
               itpc_pkg::CSR_PULSE_TIME: begin
                  pulse_time = csr_ch.data[itpc_pkg::DELAY_BITS-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed.switch_drive   = rsp_ch.switch_drive;
            observed.sensing_flag   = rsp_ch.sensing_flag;
            observed.switching_flag = rsp_ch.switching_flag;
            if (expected_outputs.size() == 0) begin
               report_error($sformatf("unexpected item: drive=%b sensing=%b switching=%b",
                  observed.switch_drive, observed.sensing_flag, observed.switching_flag));
            end else begin
               wanted = expected_outputs.pop_front();
               if (observed !== wanted) begin
                  report_error($sformatf({"mismatch: expected drive=%b sensing=%b ",
                     "switching=%b, got drive=%b sensing=%b switching=%b"},
                     wanted.switch_drive, wanted.sensing_flag, wanted.switching_flag,
                     observed.switch_drive, observed.sensing_flag,
                     observed.switching_flag));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_outputs.push_back(predict_toggle(req_ch.battery_sample,
               req_ch.state_sample, req_ch.now_ms));
         end
         outstanding = expected_outputs.size();
      end
   end

endmodule

>>> verif/inverter_toggle_pulse_controller_tb.sv
`timescale 1ns / 1ps

module inverter_toggle_pulse_controller_tb;

   typedef enum int {
      LOW_BATTERY_ON,
      HIGH_BATTERY_OFF,
      FREE_RUNNING
   } sample_mode_type;

   localparam logic [itpc_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int                                  PHASE_ITEMS      = 235;

   logic            clock;
   logic            reset;
   int              error_count;
   int              outstanding;
   logic [31:0]     now_cursor;
   sample_mode_type sample_mode;
   int              burst_left;

   // Copies of the register settings, used only to steer the stimulus.
   logic [11:0]  off_cfg;
   logic [11:0]  on_cfg;
   logic [11:0]  trigger_cfg;
   logic [15:0]  sense_cfg;
   logic [15:0]  pulse_cfg;

   itpc_req_if req_ch ();
   itpc_rsp_if rsp_ch ();
   itpc_csr_if csr_ch ();

   inverter_toggle_pulse_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   itpc_toggle_monitor toggle_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #(20_000_000);
      $display("FAILURE");
      $finish;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [11:0] at_most(input logic [11:0] level);
      if ($urandom_range(0, 7) == 0) return level;
      return 12'($urandom_range(0, level));
   endfunction

   function automatic logic [11:0] at_least(input logic [11:0] level);
      if ($urandom_range(0, 7) == 0) return level;
      return 12'($urandom_range(level, 4095));
   endfunction

   // Result backpressure: runs of ready, broken by stalls of random length.
   initial begin
      int run;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
         repeat (run) begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
         run = idle_cycles();
         repeat (run) begin
            rsp_ch.ready <= 1'b0;
            @(negedge clock);
         end
      end
   end

   task automatic write_register(input logic [itpc_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Level registers ignore the upper data bits, so those carry junk.
   task automatic apply_settings(input logic [11:0] off_level, input logic [11:0] on_level,
                                 input logic [11:0] trigger_level,
                                 input logic [15:0] sense_time,
                                 input logic [15:0] pulse_time);
      write_register(itpc_pkg::CSR_OFF_LEVEL, {4'($urandom_range(0, 15)), off_level});
      write_register(itpc_pkg::CSR_ON_LEVEL, {4'($urandom_range(0, 15)), on_level});
      write_register(itpc_pkg::CSR_TRIGGER_LEVEL, {4'($urandom_range(0, 15)), trigger_level});
      write_register(itpc_pkg::CSR_SENSE_TIME, sense_time);
      write_register(itpc_pkg::CSR_PULSE_TIME, pulse_time);
      off_cfg     = off_level;
      on_cfg      = on_level;
      trigger_cfg = trigger_level;
      sense_cfg   = sense_time;
      pulse_cfg   = pulse_time;
   endtask

   task automatic send_sample(input logic [11:0] battery, input logic [11:0] sense_line,
                              input logic [31:0] stamp);
      int gap;
      gap = (burst_left > 0) ? 0 : idle_cycles();
      if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(20, 60);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.battery_sample <= battery;
      req_ch.state_sample   <= sense_line;
      req_ch.now_ms         <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Samples tend to stay in one regime for a while so that confirmation
   // intervals and pulses actually run to completion.
   task automatic send_random_sample();
      logic [11:0] battery;
      logic [11:0] sense_line;
      int          span;
      int          pick;
      if ($urandom_range(0, 7) == 0) begin
         pick = $urandom_range(0, 19);
         sample_mode = (pick < 9) ? LOW_BATTERY_ON :
                       (pick < 16) ? HIGH_BATTERY_OFF : FREE_RUNNING;
      end
      case (sample_mode)
         LOW_BATTERY_ON: begin
            battery    = at_most(off_cfg);
            sense_line = at_most(trigger_cfg);
         end
         HIGH_BATTERY_OFF: begin
            battery    = at_least(on_cfg);
            sense_line = at_least(trigger_cfg);
         end
         default: begin
            battery    = 12'($urandom());
            sense_line = 12'($urandom());
         end
      endcase
      span = (sense_cfg > pulse_cfg) ? sense_cfg : pulse_cfg;
      if ($urandom_range(0, 39) == 0) begin
         now_cursor = $urandom();
      end else begin
         now_cursor = now_cursor + 32'($urandom_range(0, span / 3 + 3));
      end
      send_sample(battery, sense_line, now_cursor);
   endtask

   // Every item yields a result, so an empty store means the block is idle;
   // an extra wait after that covers the two-stage pipeline.
   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int span;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.battery_sample = '0;
      req_ch.state_sample   = '0;
      req_ch.now_ms         = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.data           = '0;
      now_cursor            = '0;
      sample_mode           = FREE_RUNNING;
      burst_left            = 0;
      off_cfg               = itpc_pkg::OFF_LEVEL_RESET;
      on_cfg                = itpc_pkg::ON_LEVEL_RESET;
      trigger_cfg           = itpc_pkg::TRIGGER_LEVEL_RESET;
      sense_cfg             = itpc_pkg::SENSE_TIME_RESET;
      pulse_cfg             = itpc_pkg::PULSE_TIME_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed sequence on the reset settings.
      send_sample(12'd4095, 12'd4095, 32'd100);   // turn-on pulse
      send_sample(12'd2200, 12'd2000, 32'd300);
      send_sample(12'd2200, 12'd2000, 32'd600);   // pulse ends
      send_sample(12'd0, 12'd0, 32'd700);         // sensing starts
      send_sample(12'd2100, 12'd1600, 32'd1200);  // exactly at both thresholds
      send_sample(12'd2100, 12'd1600, 32'd1700);  // confirmed, turn-off pulse
      send_sample(12'd4095, 12'd4095, 32'd2199);
      send_sample(12'd4095, 12'd4095, 32'd2200);
      send_sample(12'd4095, 12'd4095, 32'd2201);
      send_sample(12'd0, 12'd4095, 32'd2800);
      send_sample(12'd0, 12'd0, 32'd3000);
      send_sample(12'd3000, 12'd0, 32'd4000);     // condition gone at confirmation
      send_sample(12'd4095, 12'd0, 32'd4100);
      send_sample(12'd0, 12'd0, 32'hFFFF_FE00);   // sensing across the time wrap
      send_sample(12'd0, 12'd0, 32'h0000_01E7);
      send_sample(12'd0, 12'd0, 32'h0000_01E8);
      send_sample(12'd2311, 12'd1600, 32'h0000_03DC);
      send_sample(12'd2311, 12'd1600, 32'h0000_03DD);
      send_sample(12'd2101, 12'd1601, 32'hFFFF_FFFF);  // time running backwards

      for (int phase = 0; phase < 8; phase++) begin
         wait_for_idle();
         case (phase)
            0: ;
            1: apply_settings(12'($urandom_range(1500, 2500)), 12'($urandom_range(1500, 2500)),
                              12'($urandom_range(1000, 3000)), 16'($urandom_range(0, 200)),
                              16'($urandom_range(0, 200)));
            2: apply_settings(12'd0, 12'd0, 12'd0, 16'd0, 16'd0);
            3: apply_settings(12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
            4: apply_settings(12'd3000, 12'd1000, 12'($urandom()),
                              16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
            5: begin
               write_register(CSR_UNUSED_INDEX, 16'($urandom()));
               apply_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 16'd0,
                              16'($urandom_range(1, 3000)));
            end
            default: apply_settings(12'($urandom()), 12'($urandom()), 12'($urandom()),
                                    16'($urandom_range(0, 3000)),
                                    ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                                    16'($urandom_range(0, 3000)));
         endcase
         span = (sense_cfg > pulse_cfg) ? sense_cfg : pulse_cfg;
         if ($urandom_range(0, 1) == 0) begin
            now_cursor = $urandom();
         end else begin
            now_cursor = 32'd0 - 32'($urandom_range(0, 4 * span + 100));
         end
         repeat (PHASE_ITEMS) send_random_sample();
      end

      wait_for_idle();
      if (error_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
